/* hw/rtl/fpa_pkg.sv */
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int DefFractionBits = 8;
  localparam int DivStages       = 34;   // entry stage plus one per quotient bit 32..0

  typedef enum logic [3:0] {
    MODE_ADD    = 4'd0,
    MODE_SUB    = 4'd1,
    MODE_MUL    = 4'd2,
    MODE_DIV    = 4'd3,
    MODE_GT     = 4'd4,
    MODE_LT     = 4'd5,
    MODE_GE     = 4'd6,
    MODE_LE     = 4'd7,
    MODE_EQ     = 4'd8,
    MODE_NE     = 4'd9,
    MODE_MIN    = 4'd10,
    MODE_MAX    = 4'd11,
    MODE_INC    = 4'd12,
    MODE_DEC    = 4'd13,
    MODE_TO_INT = 4'd14,
    MODE_NONE   = 4'd15
  } mode_t;

  localparam logic signed [31:0] ValMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ValMin = 32'sh8000_0000;

  // classified operation, moved from front to back through the queue
  typedef struct packed {
    logic        is_mul;
    logic        is_div;
    logic        dz;
    logic        neg;
    logic [31:0] a_mag;
    logic [31:0] b_mag;
    logic [31:0] simple_res;
    logic        simple_cmp;
    logic        simple_ovf;
  } entry_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
  } sat_t;

  // rebuild a signed value from sign and magnitude, saturating to 32 bits
  function automatic sat_t signed_sat(input logic neg, input logic [63:0] mag);
    sat_t r;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.value = ValMin;
        r.ovf   = 1'b1;
      end else begin
        r.value = 32'(-mag);
        r.ovf   = 1'b0;
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r.value = ValMax;
        r.ovf   = 1'b1;
      end else begin
        r.value = mag[31:0];
        r.ovf   = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/fpa_if.sv */
`timescale 1ns / 1ps
interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic               overflow_flag;
  logic               divide_by_zero;
  modport source (output valid, result_value, compare_true, overflow_flag, divide_by_zero,
                  input ready);
  modport sink   (input valid, result_value, compare_true, overflow_flag, divide_by_zero,
                  output ready);
endinterface

/* hw/rtl/fpa_front.sv */
`timescale 1ns / 1ps
module fpa_front #(
  parameter int FRACTION_BITS = fpa_pkg::DefFractionBits
) (
  fpa_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            q_push,
  output fpa_pkg::entry_t q_entry
);
  import fpa_pkg::*;

  logic signed [31:0] a, b;
  logic signed [32:0] sum, dif;
  mode_t              md;

  assign a   = in_ch.operand_a;
  assign b   = in_ch.operand_b;
  assign md  = mode_t'(in_ch.mode);
  assign sum = {a[31], a} + {b[31], b};
  assign dif = {a[31], a} - {b[31], b};

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // classify and finish the simple operations here
  always_comb begin
    q_entry            = '0;
    q_entry.neg        = a[31] ^ b[31];
    q_entry.a_mag      = a[31] ? 32'(-a) : a;
    q_entry.b_mag      = b[31] ? 32'(-b) : b;
    case (md)
      MODE_ADD: begin
        q_entry.simple_ovf = sum[32] != sum[31];
        q_entry.simple_res = q_entry.simple_ovf ? (sum[32] ? ValMin : ValMax) : sum[31:0];
      end
      MODE_SUB: begin
        q_entry.simple_ovf = dif[32] != dif[31];
        q_entry.simple_res = q_entry.simple_ovf ? (dif[32] ? ValMin : ValMax) : dif[31:0];
      end
      MODE_MUL: q_entry.is_mul = 1'b1;
      MODE_DIV: begin
        q_entry.is_div = 1'b1;
        q_entry.dz     = b == 32'sd0;
      end
      MODE_GT:  q_entry.simple_cmp = a > b;
      MODE_LT:  q_entry.simple_cmp = a < b;
      MODE_GE:  q_entry.simple_cmp = a >= b;
      MODE_LE:  q_entry.simple_cmp = a <= b;
      MODE_EQ:  q_entry.simple_cmp = a == b;
      MODE_NE:  q_entry.simple_cmp = a != b;
      MODE_MIN: q_entry.simple_res = (a < b) ? a : b;
      MODE_MAX: q_entry.simple_res = (a > b) ? a : b;
      MODE_INC: begin
        q_entry.simple_ovf = a == ValMax;
        q_entry.simple_res = q_entry.simple_ovf ? ValMax : 32'(a + 32'sd1);
      end
      MODE_DEC: begin
        q_entry.simple_ovf = a == ValMin;
        q_entry.simple_res = q_entry.simple_ovf ? ValMin : 32'(a - 32'sd1);
      end
      MODE_TO_INT: q_entry.simple_res = a >>> FRACTION_BITS;
      default: ;
    endcase
  end
endmodule

/* hw/rtl/fpa_queue.sv */
`timescale 1ns / 1ps
module fpa_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fpa_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output fpa_pkg::entry_t head_entry
);
  import fpa_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_entry = mem_r[rd_ptr_r];

  // two-entry ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end
endmodule

/* hw/rtl/fpa_back.sv */
`timescale 1ns / 1ps
module fpa_back #(
  parameter int FRACTION_BITS = fpa_pkg::DefFractionBits
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  fpa_pkg::entry_t head_entry,
  output logic            pop,
  fpa_out_if.source       out_ch
);
  import fpa_pkg::*;

  typedef struct packed {
    entry_t      e;
    logic [62:0] rem;
    logic [32:0] den;
    logic [32:0] quo;
    logic        big;
    logic [63:0] prod;
  } stage_t;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        ovf;
    logic        dz;
  } res_t;

  localparam logic [63:0] Half = (FRACTION_BITS == 0) ? 64'd0 : (64'd1 << (FRACTION_BITS - 1));

  stage_t                 st_r  [DivStages];
  logic [DivStages-1:0]   vld_r;
  res_t                   out_r, fin;
  logic                   out_valid_r, adv;
  logic [62:0]            num;
  logic [32:0]            den;

  // whole pipeline moves together when the output register can take a result
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && head_valid;

  assign num = (63'(head_entry.a_mag) << (FRACTION_BITS + 1)) + 63'(head_entry.b_mag);
  assign den = {1'b0, head_entry.b_mag} << 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[DivStages-2:0], head_valid};
      out_valid_r <= vld_r[DivStages-1];
    end
  end

  // entry stage: product, numerator, quotient range check
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].e    <= head_entry;
      st_r[0].rem  <= num;
      st_r[0].den  <= den;
      st_r[0].quo  <= '0;
      st_r[0].big  <= (num >> 33) >= 63'(den);
      st_r[0].prod <= 64'(head_entry.a_mag) * 64'(head_entry.b_mag);
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 1; j < DivStages; j++) begin : g_div
    localparam int K = DivStages - 1 - j;
    logic [65:0] dsh;
    stage_t      nxt;
    assign dsh = 66'(st_r[j-1].den) << K;
    always_comb begin
      nxt = st_r[j-1];
      if (66'(st_r[j-1].rem) >= dsh) begin
        nxt.rem    = st_r[j-1].rem - 63'(dsh);
        nxt.quo[K] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) st_r[j] <= nxt;
    end
  end

  // final rounding and saturation
  always_comb begin
    stage_t s;
    sat_t   sat;
    s   = st_r[DivStages-1];
    sat = '0;
    fin = '0;
    if (s.e.is_mul) begin
      sat       = signed_sat(s.e.neg, (s.prod + Half) >> FRACTION_BITS);
      fin.value = sat.value;
      fin.ovf   = sat.ovf;
    end else if (s.e.is_div) begin
      if (s.e.dz) begin
        fin.dz = 1'b1;
      end else if (s.big) begin
        fin.value = s.e.neg ? ValMin : ValMax;
        fin.ovf   = 1'b1;
      end else begin
        sat       = signed_sat(s.e.neg, 64'(s.quo));
        fin.value = sat.value;
        fin.ovf   = sat.ovf;
      end
    end else begin
      fin.value = s.e.simple_res;
      fin.cmp   = s.e.simple_cmp;
      fin.ovf   = s.e.simple_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= fin;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = out_r.value;
  assign out_ch.compare_true   = out_r.cmp;
  assign out_ch.overflow_flag  = out_r.ovf;
  assign out_ch.divide_by_zero = out_r.dz;

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.dz |-> out_r.value == 32'd0 && !out_r.ovf && !out_r.cmp)
    else $error("divide by zero result not clean");
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.cmp |-> out_r.value == 32'd0 && !out_r.ovf)
    else $error("compare result carries value or overflow");
  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && out_valid_r)
    else $error("pipeline moved during output stall");
endmodule

/* hw/rtl/fixed_point_alu_q24_8.sv */
`timescale 1ns / 1ps
// channel  | dir | handshake           | payload
// in_ch    | in  | valid/ready         | mode, operand_a, operand_b
// out_ch   | out | valid/ready         | result_value, compare_true, overflow_flag, divide_by_zero
//
// One transaction per cycle sustained while the output is ready; an accepted input passes
// through the queue, then the entry stage, the 33-step restoring divide pipeline and the
// output register before output valid rises.
// A two-entry queue decouples classification from the back pipeline.
// Synchronous active-low reset clears queue pointers and stage valid bits.
// An output stall freezes the whole back pipeline; input keeps accepting until the queue fills.
module fixed_point_alu_q24_8 #(
  parameter int FRACTION_BITS = fpa_pkg::DefFractionBits
) (
  input  logic      clk,
  input  logic      rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);
  import fpa_pkg::*;

  entry_t push_entry, head_entry;
  logic   push, full, pop, head_valid;

  fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_entry(push_entry)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_entry(head_entry),
    .pop       (pop),
    .out_ch    (out_ch)
  );
endmodule

/* sim/fixed_point_alu_q24_8_test.sv */
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_test;
  import fpa_pkg::*;

  localparam int FracBits  = DefFractionBits;
  localparam int Latency   = 36;
  localparam int StallLimit = 4000;
  localparam int NumRandom = 1870;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        ovf;
    logic        dz;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fpa_in_if  in_ch ();
  fpa_out_if out_ch ();

  fixed_point_alu_q24_8 #(.FRACTION_BITS(FracBits)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  alu_result_t expected_results[$];
  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  bit  allow_gaps     = 1'b1;
  bit  hold_off       = 1'b0;
  int  hold_cycles    = 0;

  // saturate a wide signed value to 32 bits
  function automatic logic [32:0] clamp_wide(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return {1'b1, ValMax};
    if (v < -66'sd2147483648) return {1'b1, ValMin};
    return {1'b0, v[31:0]};
  endfunction

  // rebuild a signed value from sign and magnitude
  function automatic logic [32:0] from_magnitude(input logic neg, input logic [65:0] mag);
    logic signed [65:0] s;
    s = neg ? -$signed(mag) : $signed(mag);
    return clamp_wide(s);
  endfunction

  // expected ALU output for one transaction
  function automatic alu_result_t compute_alu(input mode_t mode,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    alu_result_t r;
    logic [32:0] sat;
    logic [65:0] amag, bmag, prod, num;
    logic        neg;
    r = '0;
    amag = a < 0 ? 66'(-65'(a)) : 66'(a);
    bmag = b < 0 ? 66'(-65'(b)) : 66'(b);
    neg  = (a < 0) != (b < 0);
    case (mode)
      MODE_ADD: begin
        sat = clamp_wide(66'(a) + 66'(b));
        {r.ovf, r.value} = sat;
      end
      MODE_SUB: begin
        sat = clamp_wide(66'(a) - 66'(b));
        {r.ovf, r.value} = sat;
      end
      MODE_MUL: begin
        prod = amag * bmag;
        prod = (prod + (66'(1 << FracBits) >> 1)) >> FracBits;
        {r.ovf, r.value} = from_magnitude(neg, prod);
      end
      MODE_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          num = amag << FracBits;
          {r.ovf, r.value} = from_magnitude(neg, (2 * num + bmag) / (2 * bmag));
        end
      end
      MODE_GT: r.cmp = a > b;
      MODE_LT: r.cmp = a < b;
      MODE_GE: r.cmp = a >= b;
      MODE_LE: r.cmp = a <= b;
      MODE_EQ: r.cmp = a == b;
      MODE_NE: r.cmp = a != b;
      MODE_MIN: r.value = a < b ? a : b;
      MODE_MAX: r.value = a > b ? a : b;
      MODE_INC: {r.ovf, r.value} = clamp_wide(66'(a) + 66'sd1);
      MODE_DEC: {r.ovf, r.value} = clamp_wide(66'(a) - 66'sd1);
      MODE_TO_INT: r.value = a >>> FracBits;
      default: r = '0;
    endcase
    return r;
  endfunction

  // drive one transaction and wait for acceptance
  task automatic send_op(input mode_t mode, input logic [31:0] a, input logic [31:0] b);
    int gap;
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(compute_alu(mode, a, b));
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 7))
      0: return ValMax;
      1: return ValMin;
      2: return 32'($urandom_range(0, 3)) - 32'd1;
      3: return 32'($signed(16'($urandom)));
      4: return 32'($signed(12'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  // receiver: random ready with bursts, plus an explicit long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (allow_gaps && $urandom_range(0, 7) == 0) begin
      hold_cycles  <= $urandom_range(0, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    alu_result_t got, want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.result_value, out_ch.compare_true, out_ch.overflow_flag,
               out_ch.divide_by_zero};
        if (expected_results.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected result transaction %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: value %h/%h cmp %b/%b ovf %b/%b dz %b/%b",
                       got.value, want.value, got.cmp, want.cmp, got.ovf, want.ovf,
                       got.dz, want.dz);
          end
        end
      end
    end
  end

  task automatic test_directed();
    mode_t m;
    for (int i = 0; i <= 15; i++) begin
      m = mode_t'(i);
      send_op(m, 32'h0000_0180, 32'hFFFF_FF40);
    end
    send_op(MODE_ADD, ValMax, 32'd1);
    send_op(MODE_SUB, ValMin, 32'd1);
    send_op(MODE_MUL, ValMin, ValMin);
    send_op(MODE_MUL, 32'h0000_0001, 32'h0000_0080);
    send_op(MODE_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
    send_op(MODE_DIV, 32'h0000_0100, 32'd0);
    send_op(MODE_DIV, ValMin, 32'hFFFF_FFFF);
    send_op(MODE_DIV, 32'd1, 32'd512);
    send_op(MODE_INC, ValMax, 32'd0);
    send_op(MODE_DEC, ValMin, 32'd0);
    send_op(MODE_MIN, 32'd5, 32'd5);
    send_op(MODE_TO_INT, ValMin, ValMax);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_op(mode_t'($urandom_range(0, 15)), random_operand(), random_operand());
  endtask

  // hold the output off while the sender keeps offering transactions
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(60);
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  initial begin
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_ADD;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(NumRandom - 300);
    allow_gaps = 1'b0;
    test_random(300);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
